@@ rtl/rrst_pkg.sv @@
// rrst_pkg: shared types and constants for the receive reorder / sack tracker
// holds the transaction structs, status codes, state encoding and run-queue control
// no dependencies
package rrst_pkg;

    localparam int SEQ_W = 32;

    // arrival or query, from the kind field of an input transaction
    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    typedef enum logic [2:0] {
        ST_INORDER   = 3'd0,
        ST_BUFFERED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_QUERY     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARRIVE,
        S_ABSORB,
        S_SCAN,
        S_QOUT
    } t_state;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] seq;
    } t_in;

    typedef struct packed {
        logic [SEQ_W-1:0] cum_ack;
        t_status          status;
        logic             block_valid;
        logic [SEQ_W-1:0] block_start;
        logic [SEQ_W-1:0] block_end;
        logic             last;
    } t_out;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_rq_ctrl;

endpackage

@@ rtl/rrst_run_queue.sv @@
// rrst_run_queue: keeps the most recent closed runs of a bitmap scan as offsets
// oldest entry sits at position zero; a push into a full queue drops the oldest
// depends on rrst_pkg
module rrst_run_queue import rrst_pkg::*; #(
    parameter int DEPTH = 4,
    parameter int OFF_W = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_rq_ctrl                       i_ctrl,
    input  logic [OFF_W-1:0]               i_start_off,
    input  logic [OFF_W-1:0]               i_end_off,
    output logic [OFF_W-1:0]               o_head_start,
    output logic [OFF_W-1:0]               o_head_end,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [OFF_W-1:0] r_start [DEPTH];
    logic [OFF_W-1:0] r_end   [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic             w_full;

    assign w_full = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            priority if (i_ctrl.clear) begin
                r_count <= '0;
            end else if (i_ctrl.push) begin
                if (!w_full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_ctrl.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // shift down on pop or on push into a full queue
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !w_full) begin
            r_start[r_count[IDX_W-1:0]] <= i_start_off;
            r_end[r_count[IDX_W-1:0]]   <= i_end_off;
        end else if (i_ctrl.push || i_ctrl.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_start[i] <= r_start[i+1];
                r_end[i]   <= r_end[i+1];
            end
            if (i_ctrl.push) begin
                r_start[DEPTH-1] <= i_start_off;
                r_end[DEPTH-1]   <= i_end_off;
            end
        end
    end

    assign o_head_start = r_start[0];
    assign o_head_end   = r_end[0];
    assign o_count      = r_count;

endmodule

@@ rtl/receive_reorder_sack_tracker_unit.sv @@
// receive_reorder_sack_tracker_unit: arrival tracking and sack run reporting
// arrival: registered and classified; an in-order advance then absorbs the buffered run
// query: the window is scanned, then one result per cycle (one result if empty)
// throughput: one transaction at a time; busy stays high until its last result is formed
// the bitmap scan walks one bit per cycle through a shift register copy of the window
// synchronous active-low reset clears the cumulative point, the bitmap and all control
module receive_reorder_sack_tracker_unit import rrst_pkg::*; #(
    parameter int WINDOW     = 64,
    parameter int MAX_BLOCKS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    // offset of a number above the cumulative point, and the scan counter
    localparam int OFF_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int QC_W  = $clog2(MAX_BLOCKS + 1);

    // architectural state
    t_state             r_state, n_state;
    logic [SEQ_W-1:0]   r_cp, n_cp;
    logic [WINDOW-1:0]  r_map, n_map;

    // arrival and scan working registers
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [WINDOW-1:0]  r_scan, n_scan;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_inrun, n_inrun;
    logic [OFF_W-1:0]   r_rs, n_rs;
    logic [OFF_W-1:0]   r_re, n_re;

    // result register
    logic               r_valid, n_valid;
    t_out               r_res, n_res;

    // run queue
    t_rq_ctrl           w_qctrl;
    logic [OFF_W-1:0]   w_head_s;
    logic [OFF_W-1:0]   w_head_e;
    logic [QC_W-1:0]    w_qcount;

    // arrival compare: distance above the cumulative point, no wrap
    logic [SEQ_W:0]     w_dist;
    logic               w_old;
    logic [OFF_W-1:0]   w_bitpos;
    logic [OFF_W-1:0]   w_off;

    assign w_dist   = {1'b0, r_seq} - {1'b0, r_cp};
    assign w_old    = (r_seq <= r_cp);
    // distance minus one, taken modulo the window width
    assign w_bitpos = OFF_W'(w_dist[OFF_W-1:0] - OFF_W'(1));
    assign w_off    = r_idx[OFF_W-1:0];

    rrst_run_queue #(
        .DEPTH (MAX_BLOCKS),
        .OFF_W (OFF_W)
    ) u_run_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_qctrl),
        .i_start_off  (r_rs),
        .i_end_off    (r_re),
        .o_head_start (w_head_s),
        .o_head_end   (w_head_e),
        .o_count      (w_qcount)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cp    <= '0;
            r_map   <= '0;
            r_valid <= 1'b0;
            r_inrun <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cp    <= n_cp;
            r_map   <= n_map;
            r_valid <= n_valid;
            r_inrun <= n_inrun;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_seq  <= n_seq;
        r_scan <= n_scan;
        r_idx  <= n_idx;
        r_rs   <= n_rs;
        r_re   <= n_re;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cp    = r_cp;
        n_map   = r_map;
        n_seq   = r_seq;
        n_scan  = r_scan;
        n_idx   = r_idx;
        n_inrun = r_inrun;
        n_rs    = r_rs;
        n_re    = r_re;
        n_valid = 1'b0;
        n_res   = r_res;
        w_qctrl = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.kind == KIND_QUERY) begin
                        // snapshot the window, then scan it bit by bit
                        n_scan        = r_map;
                        n_idx         = '0;
                        n_inrun       = 1'b0;
                        w_qctrl.clear = 1'b1;
                        n_state       = S_SCAN;
                    end else begin
                        n_seq   = i_item.seq;
                        n_state = S_ARRIVE;
                    end
                end
            end

            S_ARRIVE: begin
                n_res.block_valid = 1'b0;
                n_res.block_start = '0;
                n_res.block_end   = '0;
                n_res.last        = 1'b1;
                priority if (w_old) begin
                    n_res.status = ST_DUPLICATE;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else if (w_dist == (SEQ_W+1)'(1)) begin
                    // in-order: advance, then absorb any buffered run that follows
                    n_cp         = r_seq;
                    n_map        = r_map >> 1;
                    n_res.status = ST_INORDER;
                    if (n_map[0]) begin
                        n_state = S_ABSORB;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (w_dist <= (SEQ_W+1)'(WINDOW)) begin
                    for (int i = 0; i < WINDOW; i++) begin
                        if (w_bitpos == OFF_W'(i)) begin
                            n_map[i] = 1'b1;
                        end
                    end
                    n_res.status = ST_BUFFERED;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_res.status = ST_DROPPED;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
                n_res.cum_ack = n_cp;
            end

            S_ABSORB: begin
                // one buffered number per cycle
                n_cp          = r_cp + SEQ_W'(1);
                n_map         = r_map >> 1;
                n_res.cum_ack = n_cp;
                if (!n_map[0]) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_SCAN: begin
                // shifted-in zeros close a run that touches the window top
                if (r_scan[0]) begin
                    if (!r_inrun) begin
                        n_rs = w_off;
                    end
                    n_re    = w_off;
                    n_inrun = 1'b1;
                end else if (r_inrun) begin
                    w_qctrl.push = 1'b1;
                    n_inrun      = 1'b0;
                end
                n_scan = r_scan >> 1;
                n_idx  = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(WINDOW)) begin
                    n_state = S_QOUT;
                end
            end

            S_QOUT: begin
                n_res.cum_ack = r_cp;
                n_res.status  = ST_QUERY;
                n_valid       = 1'b1;
                if (w_qcount == '0) begin
                    n_res.block_valid = 1'b0;
                    n_res.block_start = '0;
                    n_res.block_end   = '0;
                    n_res.last        = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_res.block_valid = 1'b1;
                    n_res.block_start = r_cp + SEQ_W'(w_head_s) + SEQ_W'(1);
                    n_res.block_end   = r_cp + SEQ_W'(w_head_e) + SEQ_W'(1);
                    n_res.last        = (w_qcount == QC_W'(1));
                    w_qctrl.pop       = 1'b1;
                    if (w_qcount == QC_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

@@ rtl/rrst_checker.sv @@
// rrst_checker: port-level checks on the receive reorder / sack tracker
// bound to receive_reorder_sack_tracker_unit; depends on rrst_pkg
module rrst_checker import rrst_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_out o_result
);

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // an arrival result is always single and carries no run
    a_arrival_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != ST_QUERY)) |->
            (o_result.last && !o_result.block_valid))
        else $error("arrival result not single or carries a run");

    // query results come back to back until the last one
    a_runs_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> (o_valid && (o_result.status == ST_QUERY)))
        else $error("gap inside a query result burst");

    // a reported run is ordered and lies above the cumulative point
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.block_valid) |->
            ((o_result.block_start <= o_result.block_end) &&
             (o_result.block_start > o_result.cum_ack)))
        else $error("malformed sack run");

endmodule

bind receive_reorder_sack_tracker_unit rrst_checker u_rrst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
